// ----- rtl/core/tfd_pkg.sv -----
// Package for the tool-link frame deframer.
// Holds the frame byte codes, the parser phase type and the result word layout.
// No dependencies.
package tfd_pkg;

  // Sync and type byte values of the frame layout.
  localparam logic [7:0] SYNC_FIRST  = 8'h66;
  localparam logic [7:0] SYNC_SECOND = 8'hCC;
  localparam logic [7:0] TYPE_DATA   = 8'h01;
  localparam logic [7:0] TYPE_ACK    = 8'h02;

  // Stream widths.
  localparam int unsigned IN_WIDTH  = 8;
  localparam int unsigned OUT_WIDTH = 32;

  // Result word bit positions, lowest field first.
  localparam int unsigned OUT_BODY_VALID = 0;
  localparam int unsigned OUT_BODY_LSB   = 1;
  localparam int unsigned OUT_GOOD       = 9;
  localparam int unsigned OUT_BAD        = 10;
  localparam int unsigned OUT_KIND       = 11;
  localparam int unsigned OUT_LEN_LSB    = 12;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_HUNT1 = 8'b0000_0001,
    PH_HUNT2 = 8'b0000_0010,
    PH_LENH  = 8'b0000_0100,
    PH_LENL  = 8'b0000_1000,
    PH_TYPE  = 8'b0001_0000,
    PH_BODY  = 8'b0010_0000,
    PH_CHKH  = 8'b0100_0000,
    PH_CHKL  = 8'b1000_0000
  } phase_t;

  // One result item before packing.
  typedef struct packed {
    logic [15:0] frame_length;
    logic        frame_kind;
    logic        frame_bad;
    logic        frame_good;
    logic [7:0]  body_byte;
    logic        body_valid;
  } result_t;

endpackage

// ----- rtl/core/tool_frame_deframer.sv -----
// Top level of the tool-link frame deframer: byte-serial frame parser.
// Depends on tfd_pkg for byte codes, the phase type and the result layout.
//
// Channel   Direction  Width  Contents
// s_axis    in         8      tdata[7:0] = rx_byte
// m_axis    out        32     tdata: body_valid, body_byte, frame_good, frame_bad,
//                             frame_kind, frame_length (lowest bit up), zero padded
//
// Every accepted byte yields exactly one result transaction, from the output register in the next cycle.
// The parser state and the result register update in the same clock edge, so
// a new byte can be taken in every cycle while the output is not stalled: one
// byte per cycle sustained, set by the single output register. The input side is
// ready whenever the output register is empty or is being emptied in that cycle,
// so a stalled output stalls the input and nothing is lost. Synchronous active-high
// reset puts the parser in the hunt for the first sync byte with all counters and the checksum cleared.
module tool_frame_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tfd_pkg::IN_WIDTH-1:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] body_valid, [8:1] body_byte, [9] frame_good, [10] frame_bad,
  // [11] frame_kind, [27:12] frame_length, [31:28] zero
  output logic [tfd_pkg::OUT_WIDTH-1:0]  m_axis_tdata
);

  // Parser state.
  tfd_pkg::phase_t phase, phase_next;
  logic [15:0]     length_field, length_field_next;
  logic [15:0]     body_count, body_count_next;
  logic [15:0]     running_sum, running_sum_next;
  logic [7:0]      check_high, check_high_next;
  logic            kind_flag, kind_flag_next;

  // Output register.
  logic             out_valid;
  tfd_pkg::result_t result, result_next;

  logic        accept;
  logic [7:0]  rx_byte;
  logic [15:0] sum_plus;
  logic [15:0] count_plus;
  logic [15:0] need;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;

  // The checksum and body counter advance by one byte or one count at most.
  assign sum_plus   = running_sum + {8'd0, rx_byte};
  assign count_plus = body_count + 16'd1;
  // Body length is the length field minus one, but never less than one byte.
  assign need       = (length_field > 16'd1) ? (length_field - 16'd1) : 16'd1;

  always_comb begin
    phase_next        = phase;
    length_field_next = length_field;
    body_count_next   = body_count;
    running_sum_next  = running_sum;
    check_high_next   = check_high;
    kind_flag_next    = kind_flag;
    result_next       = '0;

    unique case (phase)
      tfd_pkg::PH_HUNT1: begin
        if (rx_byte == tfd_pkg::SYNC_FIRST) begin
          running_sum_next = {8'd0, tfd_pkg::SYNC_FIRST};
          body_count_next  = '0;
          phase_next       = tfd_pkg::PH_HUNT2;
        end
      end
      tfd_pkg::PH_HUNT2: begin
        // A wrong second sync byte is dropped, not retried as a first sync.
        if (rx_byte == tfd_pkg::SYNC_SECOND) begin
          running_sum_next = sum_plus;
          phase_next       = tfd_pkg::PH_LENH;
        end else begin
          phase_next = tfd_pkg::PH_HUNT1;
        end
      end
      tfd_pkg::PH_LENH: begin
        running_sum_next  = sum_plus;
        length_field_next = {rx_byte, 8'd0};
        phase_next        = tfd_pkg::PH_LENL;
      end
      tfd_pkg::PH_LENL: begin
        running_sum_next  = sum_plus;
        length_field_next = {length_field[15:8], rx_byte};
        phase_next        = tfd_pkg::PH_TYPE;
      end
      tfd_pkg::PH_TYPE: begin
        // An unknown type byte abandons the frame and keeps the old kind.
        if (rx_byte == tfd_pkg::TYPE_DATA) begin
          running_sum_next = sum_plus;
          kind_flag_next   = 1'b0;
          phase_next       = tfd_pkg::PH_BODY;
        end else if (rx_byte == tfd_pkg::TYPE_ACK) begin
          running_sum_next = sum_plus;
          kind_flag_next   = 1'b1;
          phase_next       = tfd_pkg::PH_BODY;
        end else begin
          phase_next = tfd_pkg::PH_HUNT1;
        end
      end
      tfd_pkg::PH_BODY: begin
        running_sum_next       = sum_plus;
        result_next.body_valid = 1'b1;
        result_next.body_byte  = rx_byte;
        body_count_next        = count_plus;
        if (count_plus >= need) begin
          phase_next = tfd_pkg::PH_CHKH;
        end
      end
      tfd_pkg::PH_CHKH: begin
        check_high_next = rx_byte;
        phase_next      = tfd_pkg::PH_CHKL;
      end
      tfd_pkg::PH_CHKL: begin
        // The verdict is given here and the parser goes back to hunting.
        if ({check_high, rx_byte} == running_sum) begin
          result_next.frame_good = 1'b1;
        end else begin
          result_next.frame_bad = 1'b1;
        end
        phase_next = tfd_pkg::PH_HUNT1;
      end
      default: begin
        phase_next = tfd_pkg::PH_HUNT1;
      end
    endcase

    // Kind and length show the values after this byte, also between frames.
    result_next.frame_kind   = kind_flag_next;
    result_next.frame_length = length_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tfd_pkg::PH_HUNT1;
      length_field <= '0;
      body_count   <= '0;
      running_sum  <= '0;
      check_high   <= '0;
      kind_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        length_field <= length_field_next;
        body_count   <= body_count_next;
        running_sum  <= running_sum_next;
        check_high   <= check_high_next;
        kind_flag    <= kind_flag_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only seen while out_valid is high.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(tfd_pkg::OUT_WIDTH - $bits(tfd_pkg::result_t)){1'b0}}, result};

endmodule

// ----- tb/sv/tool_frame_deframer_tb.sv -----
// Self-checking testbench for the tool-link frame deframer: directed and random frames.
// It models the parser byte by byte and checks every result transaction.
// Depends on tfd_pkg and tool_frame_deframer.
module tool_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit is several times the slowest correct run: about 2000 bytes with
  // every gap and every output stall at its longest.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // A type byte that is neither data nor control acknowledge.
  localparam logic [7:0] BOGUS_TYPE   = 8'h07;
  // Fill selector for send_frame: random body bytes.
  localparam int         FILL_RANDOM  = -1;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tfd_pkg::IN_WIDTH-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tfd_pkg::OUT_WIDTH-1:0] m_axis_tdata;

  tool_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted parser state, kept in step with every accepted byte.
  tfd_pkg::phase_t pred_phase      = tfd_pkg::PH_HUNT1;
  logic [15:0]     pred_length     = '0;
  logic [15:0]     pred_body_count = '0;
  logic [15:0]     pred_sum        = '0;
  logic [7:0]      pred_check_high = '0;
  logic            pred_kind       = 1'b0;

  tfd_pkg::result_t expected_results[$];
  int unsigned      error_count  = 0;
  int unsigned      bytes_sent   = 0;
  int unsigned      cycle_count  = 0;
  bit               gaps_enabled = 1'b1;

  // Advance the predicted parser over one received byte and return the result
  // transaction that byte must produce.
  function automatic tfd_pkg::result_t deframe_byte(input logic [7:0] b);
    tfd_pkg::result_t r;
    logic [15:0]      body_needed;
    r = '0;
    case (pred_phase)
      tfd_pkg::PH_HUNT1: begin
        if (b == tfd_pkg::SYNC_FIRST) begin
          pred_sum        = 16'(tfd_pkg::SYNC_FIRST);
          pred_body_count = '0;
          pred_phase      = tfd_pkg::PH_HUNT2;
        end
      end
      tfd_pkg::PH_HUNT2: begin
        // A wrong second sync byte is dropped, not retried as a first sync.
        if (b == tfd_pkg::SYNC_SECOND) begin
          pred_sum   = pred_sum + 16'(b);
          pred_phase = tfd_pkg::PH_LENH;
        end else begin
          pred_phase = tfd_pkg::PH_HUNT1;
        end
      end
      tfd_pkg::PH_LENH: begin
        pred_sum    = pred_sum + 16'(b);
        pred_length = {b, 8'h00};
        pred_phase  = tfd_pkg::PH_LENL;
      end
      tfd_pkg::PH_LENL: begin
        pred_sum    = pred_sum + 16'(b);
        pred_length = {pred_length[15:8], b};
        pred_phase  = tfd_pkg::PH_TYPE;
      end
      tfd_pkg::PH_TYPE: begin
        if (b == tfd_pkg::TYPE_DATA || b == tfd_pkg::TYPE_ACK) begin
          pred_sum   = pred_sum + 16'(b);
          pred_kind  = (b == tfd_pkg::TYPE_ACK);
          pred_phase = tfd_pkg::PH_BODY;
        end else begin
          // Unknown type: back to hunting, the kind of the last frame stays.
          pred_phase = tfd_pkg::PH_HUNT1;
        end
      end
      tfd_pkg::PH_BODY: begin
        pred_sum        = pred_sum + 16'(b);
        r.body_valid    = 1'b1;
        r.body_byte     = b;
        pred_body_count = pred_body_count + 16'd1;
        // Lengths of zero and one still carry a single body byte.
        body_needed = (pred_length > 16'd1) ? pred_length - 16'd1 : 16'd1;
        if (pred_body_count >= body_needed) pred_phase = tfd_pkg::PH_CHKH;
      end
      tfd_pkg::PH_CHKH: begin
        pred_check_high = b;
        pred_phase      = tfd_pkg::PH_CHKL;
      end
      default: begin
        if ({pred_check_high, b} == pred_sum) r.frame_good = 1'b1;
        else r.frame_bad = 1'b1;
        pred_phase = tfd_pkg::PH_HUNT1;
      end
    endcase
    r.frame_kind   = pred_kind;
    r.frame_length = pred_length;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one byte on the input stream, with an occasional random gap first,
  // and predict its result once the transaction is taken. Returns at the
  // falling edge after acceptance with tvalid still high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(deframe_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send one whole frame. fill is a fixed body byte value, or FILL_RANDOM.
  // When corrupt is set the checksum is flipped in at least one bit.
  task automatic send_frame(input logic [7:0] type_code, input logic [15:0] len,
                            input bit corrupt, input int fill);
    int          n_body;
    int          i;
    logic [7:0]  b;
    logic [15:0] sum;
    logic [15:0] check;
    n_body = (len > 16'd1) ? int'(len) - 1 : 1;
    sum = 16'(tfd_pkg::SYNC_FIRST) + 16'(tfd_pkg::SYNC_SECOND) + 16'(len[15:8])
          + 16'(len[7:0]) + 16'(type_code);
    send_byte(tfd_pkg::SYNC_FIRST);
    send_byte(tfd_pkg::SYNC_SECOND);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(type_code);
    for (i = 0; i < n_body; i++) begin
      b = (fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill);
      sum = sum + 16'(b);
      send_byte(b);
    end
    check = corrupt ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
    send_byte(check[15:8]);
    send_byte(check[7:0]);
  endtask

  // Shortest data frame: length zero, one body byte of all ones, good sum.
  task automatic test_length_zero_frame();
    send_frame(tfd_pkg::TYPE_DATA, 16'h0000, 1'b0, int'(8'hFF));
  endtask

  // Control acknowledge frame of length one with a zero body and a bad sum.
  task automatic test_ack_bad_checksum();
    send_frame(tfd_pkg::TYPE_ACK, 16'h0001, 1'b1, int'(8'h00));
  endtask

  // A repeated first sync is dropped, and an unknown type aborts the header
  // after the length has been taken in.
  task automatic test_broken_headers();
    send_byte(tfd_pkg::SYNC_FIRST);
    send_byte(tfd_pkg::SYNC_FIRST);
    send_byte(tfd_pkg::SYNC_FIRST);
    send_byte(tfd_pkg::SYNC_SECOND);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(BOGUS_TYPE);
  endtask

  // Mostly well-formed frames with random content and lengths, mixed with
  // line noise, broken sync pairs and frames with unknown type bytes.
  task automatic run_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    logic [7:0]  kind_byte;
    logic [7:0]  noise;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        n = $urandom_range(0, 99);
        if (n < 70) len = 16'($urandom_range(0, 8));
        else if (n < 95) len = 16'($urandom_range(9, 40));
        else len = 16'($urandom_range(200, 300));
        kind_byte = $urandom_range(0, 1) ? tfd_pkg::TYPE_ACK : tfd_pkg::TYPE_DATA;
        send_frame(kind_byte, len, ($urandom_range(0, 4) == 0), FILL_RANDOM);
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 92) begin
        send_byte(tfd_pkg::SYNC_FIRST);
        noise = 8'($urandom);
        if (noise == tfd_pkg::SYNC_SECOND) noise = ~noise;
        send_byte(noise);
      end else begin
        send_byte(tfd_pkg::SYNC_FIRST);
        send_byte(tfd_pkg::SYNC_SECOND);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        noise = 8'($urandom);
        if (noise == tfd_pkg::TYPE_DATA || noise == tfd_pkg::TYPE_ACK) noise = BOGUS_TYPE;
        send_byte(noise);
      end
    end
  endtask

  // Random traffic with gaps and stalls on both sides.
  task automatic test_random_with_gaps();
    gaps_enabled = 1'b1;
    run_random_traffic(800);
  endtask

  // Back-to-back traffic at full rate, then a frame with the upper length byte set
  // so the high length bits and a longer body count are used, then a short ack frame.
  task automatic test_random_full_rate();
    gaps_enabled = 1'b0;
    run_random_traffic(150);
    send_frame(tfd_pkg::TYPE_DATA, 16'h0104, 1'b0, FILL_RANDOM);
    send_frame(tfd_pkg::TYPE_ACK, 16'h0003, 1'b0, FILL_RANDOM);
  endtask

  // Output-side stalls come in random bursts while gaps are enabled.
  always @(negedge clk) begin
    static int stall_left = 0;
    if (stall_left > 0) stall_left--;
    else if (gaps_enabled && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    m_axis_tready <= (stall_left == 0);
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    tfd_pkg::result_t got;
    tfd_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = tfd_pkg::result_t'(m_axis_tdata[$bits(tfd_pkg::result_t)-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(m_axis_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.body_valid !== want.body_valid)
          report_mismatch("body_valid", int'(got.body_valid), int'(want.body_valid));
        if (got.body_byte !== want.body_byte)
          report_mismatch("body_byte", int'(got.body_byte), int'(want.body_byte));
        if (got.frame_good !== want.frame_good)
          report_mismatch("frame_good", int'(got.frame_good), int'(want.frame_good));
        if (got.frame_bad !== want.frame_bad)
          report_mismatch("frame_bad", int'(got.frame_bad), int'(want.frame_bad));
        if (got.frame_kind !== want.frame_kind)
          report_mismatch("frame_kind", int'(got.frame_kind), int'(want.frame_kind));
        if (got.frame_length !== want.frame_length)
          report_mismatch("frame_length", int'(got.frame_length), int'(want.frame_length));
        if (m_axis_tdata[tfd_pkg::OUT_WIDTH-1:$bits(tfd_pkg::result_t)] !== '0)
          report_mismatch("padding",
            int'(m_axis_tdata[tfd_pkg::OUT_WIDTH-1:$bits(tfd_pkg::result_t)]), 0);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_length_zero_frame();
    test_ack_bad_checksum();
    test_broken_headers();
    test_random_with_gaps();
    test_random_full_rate();

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
